// ===== rtl/lcf_pkg.sv =====
// Package: shared types, codes and the CRC-8 step function for the block framer.
package lcf_pkg;

    // Result kinds on byte_kind
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_CRC    = 2'd2;

    // CRC-8 constants: polynomial 0x07, initial 0xFF, MSB first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Reset value of the message length register
    localparam logic [15:0] MSG_LEN_RESET = 16'd1;

    // One framing command: everything the back end needs to emit an input's results
    typedef struct packed {
        logic [7:0] data;
        logic       hdr_en;
        logic [7:0] hdr_len;
        logic       crc_en;
        logic [7:0] crc;
        logic       eom;
    } cmd_t;

    // Back end emission phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_CRC
    } phase_t;

    // Fold one byte into the CRC, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/lcf_front.sv =====
// Front end: accepts bytes, tracks block position and CRC, issues framing commands.
module lcf_front #(
    parameter int BLOCK_BYTES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    input  logic           in_accept,
    input  logic [7:0]     data_byte,
    output logic           cmd_push,
    output lcf_pkg::cmd_t  cmd
);

    localparam int POS_W = $clog2(BLOCK_BYTES + 1);

    logic [15:0]      rem_reg,  rem_next;
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [POS_W-1:0] blen_reg, blen_next;
    logic [7:0]       crc_reg,  crc_next;

    logic             active;
    logic             opens;
    logic [POS_W-1:0] blen_cur;
    logic [7:0]       crc_base;
    logic [7:0]       crc_upd;
    logic [POS_W-1:0] pos_inc;
    logic             closes;
    logic [15:0]      rem_dec;

    // Classify the incoming byte against the current block
    always_comb
    begin
        active   = (rem_reg != 16'd0);
        opens    = (pos_reg == '0);
        if (rem_reg >= 16'(BLOCK_BYTES))
            blen_cur = POS_W'(BLOCK_BYTES);
        else
            blen_cur = rem_reg[POS_W-1:0];
        if (!opens)
            blen_cur = blen_reg;
        crc_base = opens ? lcf_pkg::CRC_INIT : crc_reg;
        crc_upd  = lcf_pkg::crc8_update(crc_base, data_byte);
        pos_inc  = pos_reg + POS_W'(1);
        closes   = (pos_inc >= blen_cur);
        rem_dec  = rem_reg - 16'd1;
    end

    // Build the command for the back end
    always_comb
    begin
        cmd_push    = in_accept && active;
        cmd.data    = data_byte;
        cmd.hdr_en  = opens;
        cmd.hdr_len = 8'(blen_cur);
        cmd.crc_en  = closes;
        cmd.crc     = crc_upd;
        cmd.eom     = closes && (rem_dec == 16'd0);
    end

    // Advance framing state; a configuration write restarts the message
    always_comb
    begin
        rem_next  = rem_reg;
        pos_next  = pos_reg;
        blen_next = blen_reg;
        crc_next  = crc_reg;
        if (cfg_wr_en) begin
            rem_next  = cfg_wr_data;
            pos_next  = '0;
            blen_next = '0;
            crc_next  = lcf_pkg::CRC_INIT;
        end else if (cmd_push) begin
            rem_next = rem_dec;
            if (closes) begin
                pos_next  = '0;
                blen_next = '0;
                crc_next  = lcf_pkg::CRC_INIT;
            end else begin
                pos_next  = pos_inc;
                blen_next = blen_cur;
                crc_next  = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg  <= lcf_pkg::MSG_LEN_RESET;
            pos_reg  <= '0;
            blen_reg <= '0;
            crc_reg  <= lcf_pkg::CRC_INIT;
        end else begin
            rem_reg  <= rem_next;
            pos_reg  <= pos_next;
            blen_reg <= blen_next;
            crc_reg  <= crc_next;
        end
    end

endmodule

// ===== rtl/lcf_cmd_fifo.sv =====
// Command queue: two-entry FIFO between the front and back ends.
module lcf_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lcf_pkg::cmd_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output lcf_pkg::cmd_t  rd_data,
    output logic           empty
);

    lcf_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg,  count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = ~wr_ptr_reg;
        if (rd_en)
            rd_ptr_next = ~rd_ptr_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/lcf_back.sv =====
// Back end: expands each command into header, data and CRC results into an output register.
module lcf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  lcf_pkg::cmd_t  cmd,
    output logic           cmd_pop,
    output logic [7:0]     out_byte,
    output logic [1:0]     byte_kind,
    output logic           last_of_run,
    output logic           end_of_message,
    output logic           empty,
    input  logic           pop
);

    lcf_pkg::cmd_t    cur_reg,   cur_next;
    logic             cur_v_reg, cur_v_next;
    lcf_pkg::phase_t  ph_reg,    ph_next;

    logic             out_v_reg, out_v_next;
    logic [7:0]       ob_reg,    ob_next;
    logic [1:0]       kind_reg,  kind_next;
    logic             last_reg,  last_next;
    logic             eom_reg,   eom_next;

    logic             out_free;
    logic             emit;
    logic             finish;

    assign out_byte       = ob_reg;
    assign byte_kind      = kind_reg;
    assign last_of_run    = last_reg;
    assign end_of_message = eom_reg;
    assign empty          = !out_v_reg;

    // Emit one result per cycle while output is free; load a command when idle or finished
    always_comb
    begin
        out_free   = !out_v_reg || pop;
        emit       = cur_v_reg && out_free;
        finish     = 1'b0;
        cur_next   = cur_reg;
        cur_v_next = cur_v_reg;
        ph_next    = ph_reg;
        out_v_next = out_v_reg && !pop;
        ob_next    = ob_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        eom_next   = eom_reg;
        cmd_pop    = 1'b0;

        if (emit) begin
            out_v_next = 1'b1;
            eom_next   = 1'b0;
            last_next  = 1'b0;
            case (ph_reg)
                lcf_pkg::PH_HEADER:
                begin
                    ob_next   = cur_reg.hdr_len;
                    kind_next = lcf_pkg::KIND_HEADER;
                    ph_next   = lcf_pkg::PH_DATA;
                end
                lcf_pkg::PH_DATA:
                begin
                    ob_next   = cur_reg.data;
                    kind_next = lcf_pkg::KIND_DATA;
                    if (cur_reg.crc_en) begin
                        ph_next = lcf_pkg::PH_CRC;
                    end else begin
                        last_next = 1'b1;
                        finish    = 1'b1;
                    end
                end
                lcf_pkg::PH_CRC:
                begin
                    ob_next   = cur_reg.crc;
                    kind_next = lcf_pkg::KIND_CRC;
                    eom_next  = cur_reg.eom;
                    last_next = 1'b1;
                    finish    = 1'b1;
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase
        end

        // Fetch the next command when idle or just finished
        if (!cur_v_reg || finish) begin
            cur_v_next = !cmd_empty;
            if (!cmd_empty) begin
                cmd_pop  = 1'b1;
                cur_next = cmd;
                ph_next  = cmd.hdr_en ? lcf_pkg::PH_HEADER : lcf_pkg::PH_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_v_reg <= 1'b0;
            ph_reg    <= lcf_pkg::PH_HEADER;
            out_v_reg <= 1'b0;
        end else begin
            cur_v_reg <= cur_v_next;
            ph_reg    <= ph_next;
            out_v_reg <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        ob_reg   <= ob_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
        eom_reg  <= eom_next;
    end

endmodule

// ===== rtl/length_crc8_block_framer_core.sv =====
// Top level: length-prefixed block framer with per-block CRC-8.
//
//   Channel   Handshake            Payload
//   input     push / full          data_byte[7:0]
//   result    pop / empty          out_byte[7:0], byte_kind[1:0], last_of_run, end_of_message
//   config    cfg_wr_en            cfg_wr_data[15:0] (message length)
//
// The front end takes one byte per cycle while the two-entry command queue has room.
// The back end drives one result per cycle through the output register while it is free or
// popped, so a byte that opens or closes a block yields two or three results; a stream of
// full blocks yields ten results per eight bytes, and the output port sets the throughput.
// Reset sets the message length to 1; a configuration write restarts framing.
// Either side may stall independently; the queue and output register absorb the slack.
module length_crc8_block_framer_core #(
    parameter int BLOCK_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [1:0]  byte_kind,
    output logic        last_of_run,
    output logic        end_of_message
);

    logic          in_accept;
    logic          cmd_push;
    lcf_pkg::cmd_t cmd_in;
    lcf_pkg::cmd_t cmd_out;
    logic          cmd_empty;
    logic          cmd_pop;

    // Accept a transaction whenever the queue has room
    assign in_accept = push && !full;

    lcf_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .data_byte   (data_byte),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    lcf_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    lcf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_empty      (cmd_empty),
        .cmd            (cmd_out),
        .cmd_pop        (cmd_pop),
        .out_byte       (out_byte),
        .byte_kind      (byte_kind),
        .last_of_run    (last_of_run),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop)
    );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the length-prefixed block framer with per-block CRC-8.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BLOCK  = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_GUARD  = 50000;

    // One framed output byte as the block should present it
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
        logic       eom;
    } framed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  byte_kind;
    logic        last_of_run;
    logic        end_of_message;

    // Pending message bytes and framed bytes still owed by the block
    logic [7:0] pend_q[$];
    framed_t    frame_q[$];

    int err_cnt  = 0;
    int snd_idle = 0;
    int rcv_idle = 0;

    // Framer state as the testbench tracks it
    logic [15:0] left_cnt  = lcf_pkg::MSG_LEN_RESET;
    logic [3:0]  blk_pos   = 4'd0;
    logic [3:0]  blk_len   = 4'd0;
    logic [7:0]  blk_crc   = lcf_pkg::CRC_INIT;

    length_crc8_block_framer_core #(
        .BLOCK_BYTES(FRAME_BLOCK)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .byte_kind     (byte_kind),
        .last_of_run   (last_of_run),
        .end_of_message(end_of_message)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Fold one byte into the CRC bit-serially, MSB first
    function automatic logic [7:0] crc8_fold(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[7] ^ b[i])
                r = {r[6:0], 1'b0} ^ lcf_pkg::CRC_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // Append a message byte to the pending queue
    task automatic queue_byte(input logic [7:0] b);
        pend_q = {pend_q, b};
    endtask

    // Work out the framed bytes one accepted message byte produces
    task automatic frame_byte(input logic [7:0] b);
        framed_t res[3];
        int      n;
        n = 0;
        if (left_cnt == 16'd0)
            return;
        // Open a block: header carries the block length
        if (blk_pos == 4'd0)
        begin
            blk_len = (left_cnt >= 16'(FRAME_BLOCK)) ? 4'(FRAME_BLOCK) : left_cnt[3:0];
            blk_crc = lcf_pkg::CRC_INIT;
            res[n] = framed_t'{{4'd0, blk_len}, lcf_pkg::KIND_HEADER, 1'b0, 1'b0};
            n++;
        end
        res[n] = framed_t'{b, lcf_pkg::KIND_DATA, 1'b0, 1'b0};
        n++;
        blk_crc  = crc8_fold(blk_crc, b);
        blk_pos  = blk_pos + 4'd1;
        left_cnt = left_cnt - 16'd1;
        // Close the block with its CRC
        if (blk_pos >= blk_len)
        begin
            res[n] = framed_t'{blk_crc, lcf_pkg::KIND_CRC, 1'b0, left_cnt == 16'd0};
            n++;
            blk_pos = 4'd0;
            blk_len = 4'd0;
            blk_crc = lcf_pkg::CRC_INIT;
        end
        res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            frame_q = {frame_q, res[i]};
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Driver: offer pending bytes, retire the accepted one
    always @(posedge clk)
    begin : drv
        logic       nx_push;
        logic [7:0] nx_data;
        nx_push = 1'b0;
        nx_data = data_byte;
        if (rst_n)
        begin
            if (push && !full)
            begin
                frame_byte(data_byte);
                void'(pend_q.pop_front());
            end
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= snd_idle)
            begin
                nx_push = 1'b1;
                nx_data = pend_q[0];
            end
        end
        push      <= nx_push;
        data_byte <= nx_data;
    end

    // Monitor: compare each popped transaction with the oldest expectation
    always @(posedge clk)
    begin : mon
        framed_t want;
        logic    nx_pop;
        nx_pop = 1'b0;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (frame_q.size() == 0)
                begin
                    $error("unexpected transaction: out_byte 0x%0h byte_kind %0d",
                           out_byte, byte_kind);
                    err_cnt++;
                end
                else
                begin
                    want = frame_q.pop_front();
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("byte_kind", 8'(want.kind), 8'(byte_kind));
                    check_field("last_of_run", 8'(want.last), 8'(last_of_run));
                    check_field("end_of_message", 8'(want.eom), 8'(end_of_message));
                end
            end
            nx_pop = ($urandom_range(0, 99) >= rcv_idle);
        end
        pop <= nx_pop;
    end

    // Write the message length and restart the tracked framer
    task automatic write_length(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        left_cnt = v;
        blk_pos  = 4'd0;
        blk_len  = 4'd0;
        blk_crc  = lcf_pkg::CRC_INIT;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every byte is taken and every framed byte has come out or the guard expires
    task automatic wait_quiet();
        int guard;
        guard = 0;
        while (pend_q.size() != 0 || push)
            @(posedge clk);
        while (frame_q.size() != 0 && guard < QUIET_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_message(input logic [15:0] len, input int n);
        write_length(len);
        for (int i = 0; i < n; i++)
            queue_byte(8'($urandom_range(0, 255)));
        wait_quiet();
    endtask

    initial
    begin : main
        int sel;
        int len;
        int n;
        int cnt;
        int goal;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int regime = 0; regime < 3; regime++)
        begin
            snd_idle = (regime == 0) ? 10 : (regime == 1) ? 85 : 0;
            rcv_idle = (regime == 0) ? 85 : (regime == 1) ? 10 : 0;

            if (regime == 0)
            begin
                // Reset length: one byte gives header, data and closing CRC; extra byte dropped
                queue_byte(8'h00);
                queue_byte(8'hFF);
                wait_quiet();
                // Zero length: every byte dropped
                write_length(16'd0);
                queue_byte(8'h5A);
                queue_byte(8'hA5);
                wait_quiet();
                // Exactly one full block, then a byte past the end
                write_length(16'd8);
                queue_byte(8'h00);
                queue_byte(8'hFF);
                queue_byte(8'h80);
                queue_byte(8'h01);
                queue_byte(8'h7F);
                queue_byte(8'hFE);
                queue_byte(8'h55);
                queue_byte(8'hAA);
                queue_byte(8'h3C);
                wait_quiet();
                // Full block then a one-byte block that opens and closes at once
                write_length(16'd9);
                for (int i = 0; i < 9; i++)
                    queue_byte(8'(i * 29));
                wait_quiet();
                // Largest length, abandoned mid-block by the next write
                run_message(16'hFFFF, 6);
            end

            // Random messages, mostly complete, some cut short or overrun
            cnt  = 0;
            goal = (regime == 2) ? 101 : 100;
            while (cnt < goal)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 5)
                begin
                    len = 0;
                    n   = $urandom_range(1, 3);
                end
                else if (sel < 10)
                begin
                    len = $urandom_range(100, 65535);
                    n   = $urandom_range(5, 20);
                end
                else
                begin
                    len = (sel < 22) ? $urandom_range(25, 60) : $urandom_range(1, 24);
                    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len)
                                                      : len + $urandom_range(0, 2);
                end
                run_message(16'(len), n);
                cnt += (n < len) ? n : len;
            end
        end

        wait_quiet();
        repeat (50) @(posedge clk);
        if (frame_q.size() != 0)
        begin
            $error("%0d framed bytes never arrived", frame_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== length_crc8_block_framer_core.f =====
rtl/lcf_pkg.sv
rtl/lcf_front.sv
rtl/lcf_cmd_fifo.sv
rtl/lcf_back.sv
rtl/length_crc8_block_framer_core.sv
tb/tb_top.sv
